FILE: src/hexfd_pkg.sv
// Shared types, constants and the hex digit decode for the hex text to frame decoder.
package hexfd_pkg;

    // Fixed field widths
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LIMIT_W = 14;
    localparam int unsigned FLEN_W  = 14;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;

    // Reset value of the frame byte limit
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 14'd9014;

    // One result item
    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              last_of_frame;
        logic              empty_frame;
        logic [FLEN_W-1:0] frame_length;
        logic              truncated;
    } frame_res_t;

    // Result with its strobe, parser to output buffer
    typedef struct packed {
        logic       valid;
        frame_res_t res;
    } frame_push_t;

    // Output buffer occupancy, for the top level
    typedef struct packed {
        logic main_valid;
        logic skid_valid;
    } buf_status_t;

    // Digit decode: is_hex set when the character is 0-9, A-F or a-f
    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [CHAR_W-1:0] c);
        hex_digit_t d;
        d.is_hex = 1'b1;
        d.value  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.value = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            d.value = c[3:0] + 4'd9;
        end else begin
            d.is_hex = 1'b0;
        end
        return d;
    endfunction

endpackage

FILE: src/hexfd_char_if.sv
// Character input channel: valid/ready with one text character.
interface hexfd_char_if;
    logic                          valid;
    logic                          ready;
    logic [hexfd_pkg::CHAR_W-1:0]  text_char;

    modport source (output valid, output text_char, input ready);
    modport sink   (input valid, input text_char, output ready);
endinterface

FILE: src/hexfd_frame_if.sv
// Frame output channel: valid/ready with one decoded frame result.
interface hexfd_frame_if;
    logic                          valid;
    logic                          ready;
    logic [hexfd_pkg::BYTE_W-1:0]  frame_byte;
    logic                          last_of_frame;
    logic                          empty_frame;
    logic [hexfd_pkg::FLEN_W-1:0]  frame_length;
    logic                          truncated;

    modport source (output valid, output frame_byte, output last_of_frame,
                    output empty_frame, output frame_length, output truncated,
                    input ready);
    modport sink   (input valid, input frame_byte, input last_of_frame,
                    input empty_frame, input frame_length, input truncated,
                    output ready);
endinterface

FILE: src/hex_text_to_frame_decoder_top.sv
// Top level of the hex text to frame decoder.
//
// text_in carries one ASCII character per transfer (valid/ready). Each line
// of hex digit pairs ending in 0x0A becomes one frame on frame_out: one
// transfer per decoded byte, the last one flagged last_of_frame with the
// frame length and the truncated flag. An empty line gives a single
// empty_frame transfer. One byte is held back until the next byte or the
// newline arrives, so a byte leaves when its successor is decoded.
// Throughput: one character per cycle while the skid register is empty.
// A result goes into the result register, or the skid register on a stall.
// limit_we/limit_wdata write the frame byte limit (reset 9014); write it
// only while no frame is in progress.
// Reset clears all frame state; no clearing pass is needed.
// When frame_out stalls, the result register holds and a skid register takes
// one more result; text_in.ready drops only while the skid register is full.
module hex_text_to_frame_decoder_top #(
    parameter int unsigned LENGTH_BITS = 14
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          limit_we,
    input  logic [hexfd_pkg::LIMIT_W-1:0] limit_wdata,
    hexfd_char_if.sink                    text_in,
    hexfd_frame_if.source                 frame_out
);

    hexfd_pkg::frame_push_t  push;
    hexfd_pkg::buf_status_t  status;
    logic                    can_accept;
    logic                    char_fire;

    assign text_in.ready = can_accept;
    assign char_fire     = text_in.valid && can_accept;

    // Character decode and frame state
    hexfd_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_fire   (char_fire),
        .char_in     (text_in.text_char),
        .limit_we    (limit_we),
        .limit_wdata (limit_wdata),
        .push        (push)
    );

    // Output register and skid stage
    hexfd_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .can_accept (can_accept),
        .status     (status),
        .frame_out  (frame_out)
    );

    // Skid stage only fills behind a full result register
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        status.skid_valid |-> status.main_valid)
        else $error("skid register full while result register empty");

    // Input only stalls while a result waits
    a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        !text_in.ready |-> frame_out.valid)
        else $error("input stalled with no pending result");

    // Non-final results carry no frame summary
    a_mid_frame_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_out.valid && !frame_out.last_of_frame) |->
        (!frame_out.empty_frame && frame_out.frame_length == '0 && !frame_out.truncated))
        else $error("frame summary on a non-final result");

    // Empty frames carry no byte and no length
    a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_out.valid && frame_out.empty_frame) |->
        (frame_out.last_of_frame && frame_out.frame_byte == '0 &&
         frame_out.frame_length == '0))
        else $error("empty frame with data");

endmodule

FILE: src/hexfd_parser.sv
// Pair parser: frame state, byte limit register and per-character result decode.
module hexfd_parser #(
    parameter int unsigned LENGTH_BITS = 14
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             char_fire,
    input  logic [hexfd_pkg::CHAR_W-1:0]     char_in,
    input  logic                             limit_we,
    input  logic [hexfd_pkg::LIMIT_W-1:0]    limit_wdata,
    output hexfd_pkg::frame_push_t           push
);

    localparam int unsigned CW = (LENGTH_BITS > hexfd_pkg::LIMIT_W) ?
                                 LENGTH_BITS : hexfd_pkg::LIMIT_W;
    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};

    logic [hexfd_pkg::LIMIT_W-1:0] limit_reg;
    logic                          second_due_reg, second_due_next;
    logic [3:0]                    high_nib_reg, high_nib_next;
    logic                          high_nib_valid_reg, high_nib_valid_next;
    logic [LENGTH_BITS-1:0]        count_reg, count_next;
    logic [hexfd_pkg::BYTE_W-1:0]  held_byte_reg, held_byte_next;
    logic                          held_valid_reg, held_valid_next;
    logic                          limit_hit_reg, limit_hit_next;

    logic [CW-1:0]                 limit_wide;
    logic [CW-1:0]                 count_wide;
    logic [LENGTH_BITS-1:0]        lim_eff;
    logic [LENGTH_BITS-1:0]        count_inc;
    logic                          at_limit;
    hexfd_pkg::hex_digit_t         digit;

    // Limit capped to what the counter can hold
    assign limit_wide = CW'(limit_reg);
    assign count_wide = CW'(count_reg);
    assign lim_eff    = (limit_wide > CW'(COUNT_MAX)) ? COUNT_MAX
                                                      : limit_wide[LENGTH_BITS-1:0];
    assign at_limit   = limit_hit_reg || (count_reg >= lim_eff);
    assign digit      = hexfd_pkg::hex_decode(char_in);
    assign count_inc  = count_reg + LENGTH_BITS'(1);

    // Next state and result for one accepted character
    always_comb
    begin
        second_due_next     = second_due_reg;
        high_nib_next       = high_nib_reg;
        high_nib_valid_next = high_nib_valid_reg;
        count_next          = count_reg;
        held_byte_next      = held_byte_reg;
        held_valid_next     = held_valid_reg;
        limit_hit_next      = limit_hit_reg;
        push                = '0;

        if (char_fire) begin
            if (char_in == hexfd_pkg::CHAR_NEWLINE) begin
                // end of line: flush the held byte or report an empty frame
                push.valid             = 1'b1;
                push.res.last_of_frame = 1'b1;
                push.res.truncated     = at_limit;
                if (held_valid_reg) begin
                    push.res.frame_byte   = held_byte_reg;
                    push.res.frame_length = count_wide[hexfd_pkg::FLEN_W-1:0];
                end else begin
                    push.res.empty_frame  = 1'b1;
                end
                second_due_next     = 1'b0;
                high_nib_next       = 4'd0;
                high_nib_valid_next = 1'b0;
                count_next          = '0;
                held_byte_next      = '0;
                held_valid_next     = 1'b0;
                limit_hit_next      = 1'b0;
            end else if (!at_limit) begin
                if (!second_due_reg) begin
                    // first character of a pair; a space here is skipped
                    if (char_in != hexfd_pkg::CHAR_SPACE) begin
                        second_due_next     = 1'b1;
                        high_nib_valid_next = digit.is_hex;
                        high_nib_next       = digit.is_hex ? digit.value : 4'd0;
                    end
                end else begin
                    // second character closes the pair
                    second_due_next     = 1'b0;
                    high_nib_next       = 4'd0;
                    high_nib_valid_next = 1'b0;
                    if (high_nib_valid_reg && digit.is_hex) begin
                        if (held_valid_reg) begin
                            push.valid          = 1'b1;
                            push.res.frame_byte = held_byte_reg;
                        end
                        held_byte_next  = {high_nib_reg, digit.value};
                        held_valid_next = 1'b1;
                        count_next      = count_inc;
                        if (count_inc >= lim_eff) begin
                            limit_hit_next = 1'b1;
                        end
                    end
                end
            end
        end
    end

    // Frame state and limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            limit_reg          <= hexfd_pkg::LIMIT_RESET;
            second_due_reg     <= 1'b0;
            high_nib_reg       <= 4'd0;
            high_nib_valid_reg <= 1'b0;
            count_reg          <= '0;
            held_byte_reg      <= '0;
            held_valid_reg     <= 1'b0;
            limit_hit_reg      <= 1'b0;
        end else begin
            if (limit_we) begin
                limit_reg <= limit_wdata;
            end
            second_due_reg     <= second_due_next;
            high_nib_reg       <= high_nib_next;
            high_nib_valid_reg <= high_nib_valid_next;
            count_reg          <= count_next;
            held_byte_reg      <= held_byte_next;
            held_valid_reg     <= held_valid_next;
            limit_hit_reg      <= limit_hit_next;
        end
    end

endmodule

FILE: src/hexfd_out_buf.sv
// Result register with a skid stage in front of the frame output channel.
module hexfd_out_buf (
    input  logic                     clk,
    input  logic                     rst_n,
    input  hexfd_pkg::frame_push_t   push,
    output logic                     can_accept,
    output hexfd_pkg::buf_status_t   status,
    hexfd_frame_if.source            frame_out
);

    logic                    main_valid_reg, main_valid_next;
    logic                    skid_valid_reg, skid_valid_next;
    hexfd_pkg::frame_res_t   main_reg, main_next;
    hexfd_pkg::frame_res_t   skid_reg, skid_next;
    logic                    main_free;

    assign main_free  = !main_valid_reg || frame_out.ready;
    assign can_accept = !skid_valid_reg;

    // Refill the result register from skid first, then from a new result
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (main_free) begin
            if (skid_valid_reg) begin
                main_valid_next = 1'b1;
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = push.valid;
                main_next       = push.res;
            end
        end else if (push.valid) begin
            skid_valid_next = 1'b1;
            skid_next       = push.res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign status.main_valid     = main_valid_reg;
    assign status.skid_valid     = skid_valid_reg;
    assign frame_out.valid         = main_valid_reg;
    assign frame_out.frame_byte    = main_reg.frame_byte;
    assign frame_out.last_of_frame = main_reg.last_of_frame;
    assign frame_out.empty_frame   = main_reg.empty_frame;
    assign frame_out.frame_length  = main_reg.frame_length;
    assign frame_out.truncated     = main_reg.truncated;

endmodule

FILE: tb/frame_scoreboard_pkg.sv
// Scoreboard class for the hex text decoder: predicts frame results from accepted characters.
package frame_scoreboard_pkg;

    import hexfd_pkg::*;

    class frame_scoreboard;
        // Decoder state as the scoreboard tracks it
        logic [LIMIT_W-1:0] byte_limit;
        bit                 pair_open;
        logic [3:0]         upper_nibble;
        bit                 upper_ok;
        logic [FLEN_W-1:0]  frame_bytes;
        logic [BYTE_W-1:0]  held_byte;
        bit                 held_ok;
        bit                 cut_short;

        // Results still owed by the decoder, oldest first
        frame_res_t         frames_due[$];
        int unsigned        errors;

        function new();
            byte_limit = LIMIT_RESET;
            errors     = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            pair_open    = 1'b0;
            upper_nibble = 4'd0;
            upper_ok     = 1'b0;
            frame_bytes  = '0;
            held_byte    = '0;
            held_ok      = 1'b0;
            cut_short    = 1'b0;
        endfunction

        // With 14 count bits every 14-bit limit is reachable, so no capping
        function void set_limit(logic [LIMIT_W-1:0] v);
            byte_limit = v;
        endfunction

        // Bit 4 set: not a hex digit; otherwise bits 3:0 carry the value
        function logic [4:0] digit_of(logic [CHAR_W-1:0] c);
            if (c >= 8'h30 && c <= 8'h39)
                return {1'b0, c[3:0]};
            if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
                return {1'b0, 4'(c[3:0] + 4'd9)};
            return 5'h10;
        endfunction

        // One character accepted on text_in: update state, queue any result it causes
        function void take_char(logic [CHAR_W-1:0] c);
            frame_res_t r;
            logic [4:0] d;
            r = '0;

            // Newline closes the frame, even half way through a pair
            if (c == CHAR_NEWLINE)
            begin
                r.last_of_frame = 1'b1;
                r.truncated     = cut_short || (frame_bytes >= byte_limit);
                if (held_ok)
                begin
                    r.frame_byte   = held_byte;
                    r.frame_length = frame_bytes;
                end
                else
                    r.empty_frame = 1'b1;
                frames_due.push_back(r);
                restart_frame();
                return;
            end

            // Limit reached: rest of the line is dropped
            if (cut_short || frame_bytes >= byte_limit)
                return;

            d = digit_of(c);

            // First character of a pair; a space here is skipped
            if (!pair_open)
            begin
                if (c == CHAR_SPACE)
                    return;
                pair_open    = 1'b1;
                upper_ok     = !d[4];
                upper_nibble = d[3:0];
                return;
            end

            // Second character: a byte only when both halves are hex
            pair_open = 1'b0;
            if (upper_ok && !d[4])
            begin
                if (held_ok)
                begin
                    r.frame_byte = held_byte;
                    frames_due.push_back(r);
                end
                held_byte   = {upper_nibble, d[3:0]};
                held_ok     = 1'b1;
                frame_bytes = frame_bytes + FLEN_W'(1);
                if (frame_bytes >= byte_limit)
                    cut_short = 1'b1;
            end
            upper_nibble = 4'd0;
            upper_ok     = 1'b0;
        endfunction

        task report(string what);
            $display("[%0t] %s", $time, what);
            errors++;
        endtask

        // One result accepted on frame_out: compare with the oldest one owed
        task check_frame(frame_res_t got);
            frame_res_t want;
            if (frames_due.size() == 0)
            begin
                report($sformatf("unexpected result: byte %02h last %0b empty %0b",
                                 got.frame_byte, got.last_of_frame, got.empty_frame));
                return;
            end
            want = frames_due.pop_front();
            if (got.frame_byte !== want.frame_byte)
                report($sformatf("frame_byte %02h, expected %02h",
                                 got.frame_byte, want.frame_byte));
            if (got.last_of_frame !== want.last_of_frame)
                report($sformatf("last_of_frame %0b, expected %0b",
                                 got.last_of_frame, want.last_of_frame));
            if (got.empty_frame !== want.empty_frame)
                report($sformatf("empty_frame %0b, expected %0b",
                                 got.empty_frame, want.empty_frame));
            if (got.frame_length !== want.frame_length)
                report($sformatf("frame_length %0d, expected %0d",
                                 got.frame_length, want.frame_length));
            if (got.truncated !== want.truncated)
                report($sformatf("truncated %0b, expected %0b",
                                 got.truncated, want.truncated));
        endtask
    endclass

endpackage

FILE: tb/tb_top.sv
// Testbench top: drives character lines into the hex text decoder and checks every frame result.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import hexfd_pkg::*;
    import frame_scoreboard_pkg::*;

    localparam int unsigned QUIET_LIMIT   = 2000;
    localparam int unsigned PHASE_CHARS   = 150;
    localparam int unsigned RANDOM_PHASES = 8;

    typedef enum int unsigned {RX_ALWAYS, RX_RANDOM, RX_RUNS} rx_pattern_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               limit_we;
    logic [LIMIT_W-1:0] limit_wdata;

    hexfd_char_if  text_ch();
    hexfd_frame_if frame_ch();

    rx_pattern_t     rx_pattern   = RX_ALWAYS;
    bit              tx_bursty    = 1'b0;
    int unsigned     burst_left   = 0;
    int unsigned     chars_sent   = 0;
    int unsigned     quiet_cycles = 0;
    frame_scoreboard sb = new();

    hex_text_to_frame_decoder_top #(
        .LENGTH_BITS(14)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .limit_we    (limit_we),
        .limit_wdata (limit_wdata),
        .text_in     (text_ch),
        .frame_out   (frame_ch)
    );

    always #10 clk = ~clk;

    // Receiver back-pressure, pattern chosen per phase
    initial
    begin : receiver
        int unsigned run_left;
        logic        level;
        run_left = 0;
        level    = 1'b0;
        frame_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            case (rx_pattern)
                RX_ALWAYS: frame_ch.ready <= 1'b1;
                RX_RANDOM: frame_ch.ready <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    // alternating runs of ready and stall
                    if (run_left == 0)
                    begin
                        level    = ~level;
                        run_left = level ? $urandom_range(1, 12) : $urandom_range(1, 20);
                    end
                    run_left--;
                    frame_ch.ready <= level;
                end
            endcase
        end
    end

    // Transfer monitor and watchdog
    always @(posedge clk)
    begin : monitor
        frame_res_t seen;
        bit         moved;
        if (rst_n === 1'b1)
        begin
            moved = 1'b0;
            if (frame_ch.valid === 1'b1 && frame_ch.ready === 1'b1)
            begin
                seen.frame_byte    = frame_ch.frame_byte;
                seen.last_of_frame = frame_ch.last_of_frame;
                seen.empty_frame   = frame_ch.empty_frame;
                seen.frame_length  = frame_ch.frame_length;
                seen.truncated     = frame_ch.truncated;
                sb.check_frame(seen);
                moved = 1'b1;
            end
            if (text_ch.valid === 1'b1 && text_ch.ready === 1'b1)
            begin
                sb.take_char(text_ch.text_char);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("no transfer for %0d cycles, giving up", QUIET_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // One character transfer, with a random gap at the end of each burst
    task automatic send_char(input logic [CHAR_W-1:0] c);
        int unsigned gap;
        if (tx_bursty && burst_left == 0)
        begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
            if (gap != 0)
            begin
                text_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        text_ch.valid     <= 1'b1;
        text_ch.text_char <= c;
        @(posedge clk);
        while (text_ch.ready !== 1'b1) @(posedge clk);
        if (burst_left != 0)
            burst_left--;
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // Hex digit character, case picked at random
    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + n;
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
    endfunction

    // Mostly clean lines of pairs; some with noise, some ending mid-pair, some raw junk
    task automatic send_random_line();
        int unsigned       kind;
        int unsigned       n_pairs;
        logic [BYTE_W-1:0] b;
        kind = $urandom_range(0, 99);
        if (kind >= 93)
        begin
            repeat ($urandom_range(1, 20)) send_char(CHAR_W'($urandom_range(0, 255)));
            return;
        end
        n_pairs = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
        for (int i = 0; i < n_pairs; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                send_char(CHAR_SPACE);
            b = BYTE_W'($urandom_range(0, 255));
            if (kind >= 70 && kind < 85 && $urandom_range(0, 4) == 0)
            begin
                send_char(CHAR_W'($urandom_range(0, 255)));
                send_char(hex_char(b[3:0]));
            end
            else
            begin
                send_char(hex_char(b[7:4]));
                send_char(hex_char(b[3:0]));
            end
        end
        if (kind >= 85)
            send_char(hex_char(4'($urandom_range(0, 15))));
        send_char(CHAR_NEWLINE);
    endtask

    // Stop sending and let every owed result drain, then a short pause
    task automatic settle();
        text_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.frames_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        limit_we    <= 1'b1;
        limit_wdata <= v;
        @(posedge clk);
        limit_we    <= 1'b0;
        sb.set_limit(v);
    endtask

    initial
    begin : stimulus
        int unsigned       target;
        logic [LIMIT_W-1:0] lim;
        text_ch.valid     <= 1'b0;
        text_ch.text_char <= '0;
        limit_we          <= 1'b0;
        limit_wdata       <= '0;
        rst_n             <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines at the reset limit, receiver stalling in runs
        rx_pattern = RX_RUNS;
        send_text("\n");        // empty line
        send_text("00 Ff\n");   // byte extremes, space between pairs
        send_text("aF9z\n");    // mixed case, then a pair with a non-hex half
        send_text(" 3\n");      // leading space, newline closing a pair
        send_text("1 e0\n");    // space as the second half of a pair
        send_char(8'hFF);       // character extremes as a dud pair
        send_char(8'h00);
        send_char(CHAR_NEWLINE);
        settle();

        // Limit of one byte: frame cut after one byte, rest of line ignored
        write_limit(14'd1);
        send_text("0102\n");
        settle();

        // Random phases, each with its own limit and idling pattern
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       lim = 14'd16383;
                1:       lim = 14'd1;
                2:       lim = LIMIT_W'($urandom_range(2, 6));
                3:       lim = LIMIT_RESET;
                4:       lim = LIMIT_W'($urandom_range(1, 12));
                5:       lim = LIMIT_W'($urandom_range(1, 16383));
                6:       lim = 14'd3;
                default: lim = LIMIT_W'($urandom_range(1, 8));
            endcase
            write_limit(lim);
            tx_bursty  = (p % 4 != 0);
            rx_pattern = rx_pattern_t'(p % 3);
            target = chars_sent + PHASE_CHARS;
            while (chars_sent < target)
                send_random_line();
            settle();
        end

        if (sb.frames_due.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.frames_due.size()));
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
src/hexfd_pkg.sv
src/hexfd_char_if.sv
src/hexfd_frame_if.sv
src/hexfd_parser.sv
src/hexfd_out_buf.sv
src/hex_text_to_frame_decoder_top.sv
tb/frame_scoreboard_pkg.sv
tb/tb_top.sv
